// ----- rtl/deque_ring_buffer_macros.svh -----
// ----------------------------------------------------------------------------
// Deque ring buffer assertion macros
// Shared concurrent assertion forms for the deque ring buffer.
// ----------------------------------------------------------------------------
`ifndef DEQUE_RING_BUFFER_MACROS_SVH
`define DEQUE_RING_BUFFER_MACROS_SVH

// check a condition at every clock edge outside reset
`define DQRB_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check a consequence in the cycle after its trigger
`define DQRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dqrb_pkg.sv -----
// ----------------------------------------------------------------------------
// Deque ring buffer package
// Operation codes, status codes and word types of the deque ring buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dqrb_pkg;

	localparam int unsigned FIELD_W = 32;
	localparam int unsigned COUNT_W = 11;

	localparam logic [2:0] OP_QUERY      = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_POP_BACK   = 3'd4;

	localparam logic signed [FIELD_W-1:0] NEG_ONE = '1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]                 operation;
		logic signed [FIELD_W-1:0]  push_value;
	} in_t;

	typedef struct packed {
		status_t                    status;
		logic signed [FIELD_W-1:0]  popped_value;
		logic [COUNT_W-1:0]         entry_count;
		logic                       is_empty;
		logic signed [FIELD_W-1:0]  front_item;
		logic signed [FIELD_W-1:0]  back_item;
	} out_t;

endpackage

// ----- rtl/dqrb_mem.sv -----
// ----------------------------------------------------------------------------
// Deque ring buffer item store
// One write port and two registered read ports, write-first on a collision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dqrb_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem_q[raddr_a];
			rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem_q[raddr_b];
		end
	end

endmodule

// ----- rtl/deque_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// Deque ring buffer
// One word accepted every cycle; busy stays low. Result strobes on done once the
// word has passed the input register, then store access and result register.
// Reset clears pointers and count; store contents stay undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deque_ring_buffer_macros.svh"

module deque_ring_buffer
	import dqrb_pkg::*;
#(
	parameter int unsigned DEPTH      = 1024,
	parameter int unsigned ITEM_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic                  accept;
	logic                  valid_s1;
	logic [2:0]            op_s1;
	logic [FIELD_W-1:0]    val_s1;
	logic                  valid_s2;
	status_t               status_s2;
	logic [FIELD_W-1:0]    popped_s2;

	logic [PW-1:0]         front_q;
	logic [PW-1:0]         back_q;
	logic [CW-1:0]         count_q;

	logic [PW-1:0]         front_nx;
	logic [PW-1:0]         back_nx;
	logic [CW-1:0]         count_nx;
	logic [PW-1:0]         front_dec;
	logic [PW-1:0]         front_inc;
	logic [PW-1:0]         back_dec;
	logic [PW-1:0]         back_inc;
	logic [PW-1:0]         back_nx_dec;
	logic                  is_full;
	logic                  is_empty_now;
	status_t               status_nx;
	logic [FIELD_W-1:0]    popped_nx;

	logic                  mem_we;
	logic [PW-1:0]         mem_waddr;
	logic [ITEM_WIDTH-1:0] rd_front;
	logic [ITEM_WIDTH-1:0] rd_back;
	logic [FIELD_W-1:0]    front_ext;
	logic [FIELD_W-1:0]    back_ext;

	logic [CW:0]           ptr_sum;
	logic [CW:0]           ptr_wrap;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= item.operation;
			val_s1 <= item.push_value;
		end
	end

	assign front_dec    = (front_q == '0) ? PTR_LAST : front_q + 1'b1 - 2'(2);
	assign front_inc    = (front_q == PTR_LAST) ? '0 : front_q + 1'b1;
	assign back_dec     = (back_q == '0) ? PTR_LAST : back_q - 1'b1;
	assign back_inc     = (back_q == PTR_LAST) ? '0 : back_q + 1'b1;
	assign back_nx_dec  = (back_nx == '0) ? PTR_LAST : back_nx - 1'b1;
	assign is_full      = (count_q == CNT_FULL);
	assign is_empty_now = (count_q == '0);

	assign front_ext = FIELD_W'($signed(rd_front));
	assign back_ext  = FIELD_W'($signed(rd_back));

	always_comb begin
		front_nx  = front_q;
		back_nx   = back_q;
		count_nx  = count_q;
		mem_we    = 1'b0;
		mem_waddr = back_q;
		status_nx = ST_OK;
		popped_nx = '0;
		unique case (op_s1)
			OP_PUSH_FRONT: begin
				if (is_full) begin
					status_nx = ST_FULL;
				end else begin
					front_nx  = front_dec;
					mem_we    = valid_s1;
					mem_waddr = front_dec;
					count_nx  = count_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					status_nx = ST_FULL;
				end else begin
					back_nx   = back_inc;
					mem_we    = valid_s1;
					mem_waddr = back_q;
					count_nx  = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (is_empty_now) begin
					status_nx = ST_EMPTY;
					popped_nx = NEG_ONE;
				end else begin
					front_nx  = front_inc;
					popped_nx = front_ext;
					count_nx  = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty_now) begin
					status_nx = ST_EMPTY;
					popped_nx = NEG_ONE;
				end else begin
					back_nx   = back_dec;
					popped_nx = back_ext;
					count_nx  = count_q - 1'b1;
				end
			end
			default: begin
				if (is_empty_now) begin
					status_nx = ST_EMPTY;
				end
			end
		endcase
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			back_q   <= '0;
			count_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				front_q <= front_nx;
				back_q  <= back_nx;
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= status_nx;
			popped_s2 <= popped_nx;
		end
	end

	dqrb_mem #(
		.DEPTH (DEPTH),
		.WIDTH (ITEM_WIDTH)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (ITEM_WIDTH'(val_s1)),
		.re      (valid_s1),
		.raddr_a (front_nx),
		.raddr_b (back_nx_dec),
		.rdata_a (rd_front),
		.rdata_b (rd_back)
	);

	assign done                = valid_s2;
	assign result.status       = status_s2;
	assign result.popped_value = popped_s2;
	assign result.entry_count  = COUNT_W'(count_q);
	assign result.is_empty     = is_empty_now;
	assign result.front_item   = is_empty_now ? NEG_ONE : front_ext;
	assign result.back_item    = is_empty_now ? NEG_ONE : back_ext;

	assign ptr_sum  = (CW + 1)'(front_q) + (CW + 1)'(count_q);
	assign ptr_wrap = (ptr_sum >= (CW + 1)'(DEPTH)) ? ptr_sum - (CW + 1)'(DEPTH) : ptr_sum;

	`DQRB_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_FULL,
		"deque count exceeds depth")
	`DQRB_ASSERT_ALWAYS(a_ring_consistent, clk, arst_n, PW'(ptr_wrap) == back_q,
		"front pointer plus count does not reach back pointer")
	`DQRB_ASSERT_NEXT(a_done_follows, clk, arst_n, valid_s1, done,
		"result strobe missing after accepted word")
	`DQRB_ASSERT_NEXT(a_no_stray_done, clk, arst_n, !valid_s1, !done,
		"result strobe without accepted word")

endmodule
